// ----- src/abd_pkg.sv -----
// ----------------------------------------------------------------------------
// audio beat detector package
// shared payload types, configuration indexes and loudness thresholds
// ----------------------------------------------------------------------------
`default_nettype none
package abd_pkg;

    localparam int LOUD_W = 20;
    localparam int DEV_W  = LOUD_W + 1;

    localparam logic [LOUD_W-1:0] BEAT_LEVEL  = LOUD_W'(2000);
    localparam logic [LOUD_W-1:0] THICK_LEVEL = LOUD_W'(1500);
    localparam logic [LOUD_W-1:0] QUIET_LEVEL = LOUD_W'(500);
    localparam int                MIN_PERIOD  = 15;
    localparam logic [1:0]        BOOST_MAX   = 2'd3;

    typedef enum logic {
        CFG_SENSITIVITY = 1'b0,
        CFG_THICK_MODE  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [LOUD_W-1:0] frame_loudness;
        logic              force_quiet;
    } abd_in_t;

    typedef struct packed {
        logic       beat_found;
        logic [1:0] line_thickness;
        logic       quiet_start;
    } abd_out_t;

endpackage
`default_nettype wire

// ----- src/abd_ram.sv -----
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module abd_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 200
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- src/abd_div.sv -----
// ----------------------------------------------------------------------------
// divider by a constant
// reciprocal multiplication split into a low-half and a high-half product, done pulses at the end
// ----------------------------------------------------------------------------
`default_nettype none
module abd_div #(
    parameter int WIDTH   = 33,
    parameter int DIVISOR = 200
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    output logic                  done,
    output logic      [WIDTH-1:0] quotient
);
    localparam int ShW     = $clog2(DIVISOR);
    localparam int Sh      = WIDTH + ShW;
    localparam int RecW    = WIDTH + 1;
    localparam int LoW     = RecW / 2;
    localparam int HiW     = RecW - LoW;
    localparam int LoProdW = WIDTH + LoW;
    localparam int SumW    = WIDTH + HiW + 1;
    // reciprocal rounded up, exact for every dividend below 2**WIDTH
    localparam logic [RecW-1:0] Recip =
        RecW'(((64'd1 << Sh) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [LoW-1:0]  RecLo = Recip[LoW-1:0];
    localparam logic [HiW-1:0]  RecHi = Recip[RecW-1:LoW];

    logic [WIDTH-1:0]   x_reg, x_next;
    logic [LoProdW-1:0] lo_reg, lo_next;
    logic [WIDTH-1:0]   q_reg, q_next;
    logic               ph1_reg, ph1_next;
    logic               ph2_reg, ph2_next;
    logic               done_reg, done_next;
    logic [SumW-1:0]    sum;

    // low half of the reciprocal first, high half with the final shift next
    always_comb begin
        sum       = SumW'(x_reg * RecHi) + SumW'(lo_reg[LoProdW-1:LoW]);
        x_next    = start ? dividend : x_reg;
        lo_next   = ph1_reg ? LoProdW'(x_reg * RecLo) : lo_reg;
        q_next    = ph2_reg ? WIDTH'(sum >> (Sh - LoW)) : q_reg;
        ph1_next  = start;
        ph2_next  = ph1_reg;
        done_next = ph2_reg;
    end

    always_ff @(posedge aclk) begin
        x_reg  <= x_next;
        lo_reg <= lo_next;
        q_reg  <= q_next;
        if (!aresetn) begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            ph1_reg  <= ph1_next;
            ph2_reg  <= ph2_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

// ----- src/audio_beat_detector_core.sv -----
// sequence: a frame that is not a beat candidate passes through write and finish; a candidate
// walks n = HISTORY_DEPTH/period - 1 ring entries, each in an address and a data step, then
// multiplies and checks, adding the reciprocal divide when its scaled total is positive
// flow: one frame at a time, the next frame is taken only after the result is registered;
// s_ready is high only while idle, a stalled result holds the sequencer
// reset: synchronous active-low; state and ring valid bits clear at once, no clearing pass
// ----------------------------------------------------------------------------
// audio beat detector core
// smoothed loudness, deviation ring and beat confirmation under a small sequencer
// ----------------------------------------------------------------------------
`default_nettype none
module audio_beat_detector_core #(
    parameter int HISTORY_DEPTH = 200
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire abd_pkg::abd_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output abd_pkg::abd_out_t     m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [3:0]       cfg_wdata
);
    import abd_pkg::*;

    localparam int IdxW = $clog2(HISTORY_DEPTH);
    localparam int CntW = $clog2(HISTORY_DEPTH + 2);
    localparam int MW   = $clog2(2 * HISTORY_DEPTH + 1);
    localparam int AccW = DEV_W + $clog2(HISTORY_DEPTH / 16 + 1);
    localparam int PW   = AccW + CntW + 1;
    localparam int QW   = PW - 1;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_WRITE    = 9'b000000010,
        ST_SUM_ADDR = 9'b000000100,
        ST_SUM_DATA = 9'b000001000,
        ST_MUL      = 9'b000010000,
        ST_CHECK    = 9'b000100000,
        ST_DIV      = 9'b001000000,
        ST_MULQ     = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]               sens_cfg_reg, sens_cfg_next;
    logic                     thick_cfg_reg, thick_cfg_next;
    logic [LOUD_W-1:0]        smoothed_reg, smoothed_next;
    logic [CntW-1:0]          fsb_reg, fsb_next;
    logic [CntW-1:0]          prev_reg, prev_next;
    logic [IdxW-1:0]          base_reg, base_next;
    logic                     was_quiet_reg, was_quiet_next;
    logic [HISTORY_DEPTH-1:0] valid_reg, valid_next;
    logic                     m_valid_reg, m_valid_next;
    abd_out_t                 m_data_reg, m_data_next;

    logic [LOUD_W-1:0] aged_reg, aged_next;
    logic [DEV_W-1:0]  dev_reg, dev_next;
    logic [CntW-1:0]   elapsed_reg, elapsed_next;
    logic [IdxW-1:0]   slot_reg, slot_next;
    logic              clear_reg, clear_next;
    logic              cand_reg, cand_next;
    logic [1:0]        thick_reg, thick_next;
    logic              quiet_reg, quiet_next;
    logic [IdxW-1:0]   j_reg, j_next;
    logic [MW-1:0]     m_reg, m_next;
    logic [AccW-1:0]   acc_reg, acc_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [4:0]        sens_reg, sens_next;
    logic              beat_reg, beat_next;
    logic              vq_reg;

    logic [LOUD_W-1:0] loud, aged;
    logic [LOUD_W+2:0] sum7, loud5, aged5;
    logic [CntW-1:0]   elapsed_inc, elapsed;
    logic              clear;
    logic [CntW:0]     slot_sum;
    logic [LOUD_W+1:0] loud2, aged3;
    logic [1:0]        thick;
    logic              quiet_cond;
    logic [CntW:0]     j_ext, j_back;
    logic [CntW-1:0]   diff, half;
    logic [1:0]        boost;
    logic [DEV_W-1:0]  rd_data;
    logic [QW-1:0]     quot;
    logic              div_start, div_done, out_free;

    // frame front end
    always_comb begin
        loud        = s_data.frame_loudness;
        sum7        = {smoothed_reg, 3'b000} - {3'b000, smoothed_reg} + {3'b000, loud};
        aged        = sum7[LOUD_W+2:3];
        elapsed_inc = fsb_reg + CntW'(1);
        clear       = (aged < BEAT_LEVEL) || (elapsed_inc > CntW'(HISTORY_DEPTH));
        elapsed     = clear ? '0 : elapsed_inc;
        slot_sum    = {1'b0, elapsed} + (CntW+1)'(base_reg);
        loud5       = {1'b0, loud, 2'b00};
        aged5       = {1'b0, aged, 2'b00} + {3'b000, aged};
        loud2       = {1'b0, loud, 1'b0};
        aged3       = {1'b0, aged, 1'b0} + {2'b00, aged};
        if (aged < THICK_LEVEL) begin
            thick = 2'd0;
        end else if (!thick_cfg_reg) begin
            thick = 2'd1;
        end else if (loud2 >= aged3) begin
            thick = 2'd3;
        end else if (loud >= aged) begin
            thick = 2'd2;
        end else if (loud2 >= {2'b00, aged}) begin
            thick = 2'd1;
        end else begin
            thick = 2'd0;
        end
        quiet_cond = s_data.force_quiet ||
                     (aged < (was_quiet_reg ? THICK_LEVEL : QUIET_LEVEL));
    end

    // ring walk step and period-match boost
    always_comb begin
        j_ext  = (CntW+1)'(j_reg);
        j_back = (j_ext >= {1'b0, elapsed_reg}) ? j_ext - {1'b0, elapsed_reg}
                 : j_ext + (CntW+1)'(HISTORY_DEPTH) - {1'b0, elapsed_reg};
        diff   = (elapsed_reg > prev_reg) ? elapsed_reg - prev_reg : prev_reg - elapsed_reg;
        half   = diff >> 1;
        boost  = (half < CntW'(BOOST_MAX)) ? BOOST_MAX - half[1:0] : 2'd0;
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == ST_CHECK) && !prod_reg[PW-1] && (prod_reg != '0);

    always_comb begin
        state_next     = state_reg;
        sens_cfg_next  = sens_cfg_reg;
        thick_cfg_next = thick_cfg_reg;
        smoothed_next  = smoothed_reg;
        fsb_next       = fsb_reg;
        prev_next      = prev_reg;
        base_next      = base_reg;
        was_quiet_next = was_quiet_reg;
        valid_next     = valid_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        aged_next      = aged_reg;
        dev_next       = dev_reg;
        elapsed_next   = elapsed_reg;
        slot_next      = slot_reg;
        clear_next     = clear_reg;
        cand_next      = cand_reg;
        thick_next     = thick_reg;
        quiet_next     = quiet_reg;
        j_next         = j_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        sens_next      = sens_reg;
        beat_next      = beat_reg;

        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SENSITIVITY: sens_cfg_next  = cfg_wdata;
                CFG_THICK_MODE:  thick_cfg_next = cfg_wdata[0];
                default: ;
            endcase
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    smoothed_next  = aged;
                    was_quiet_next = quiet_cond;
                    aged_next      = aged;
                    dev_next       = {1'b0, loud} - {1'b0, aged};
                    elapsed_next   = elapsed;
                    slot_next      = (slot_sum >= (CntW+1)'(HISTORY_DEPTH))
                                     ? IdxW'(slot_sum - (CntW+1)'(HISTORY_DEPTH))
                                     : IdxW'(slot_sum);
                    clear_next     = clear;
                    cand_next      = (elapsed > CntW'(MIN_PERIOD)) && (aged > BEAT_LEVEL)
                                     && (loud5 > aged5);
                    thick_next     = thick;
                    quiet_next     = quiet_cond && !was_quiet_reg;
                    state_next     = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // loudness below the beat level or an overlong period empties the ring before this write
                if (clear_reg) begin
                    valid_next = '0;
                end
                valid_next[slot_reg] = 1'b1;
                j_next     = slot_reg;
                m_next     = MW'({elapsed_reg, 1'b0});
                acc_next   = '0;
                beat_next  = 1'b0;
                state_next = cand_reg ? ST_SUM_ADDR : ST_FINISH;
            end
            ST_SUM_ADDR: begin
                state_next = (m_reg <= MW'(HISTORY_DEPTH)) ? ST_SUM_DATA : ST_MUL;
            end
            ST_SUM_DATA: begin
                if (vq_reg) begin
                    acc_next = acc_reg + AccW'($signed(rd_data));
                end
                j_next     = IdxW'(j_back);
                m_next     = m_reg + MW'(elapsed_reg);
                state_next = ST_SUM_ADDR;
            end
            ST_MUL: begin
                prod_next  = PW'($signed(acc_reg) * $signed({1'b0, elapsed_reg}));
                sens_next  = {1'b0, sens_cfg_reg} + {3'b000, boost};
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // a non-positive scaled total can never beat a positive level
                state_next = div_start ? ST_DIV : ST_FINISH;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MULQ;
                end
            end
            ST_MULQ: begin
                beat_next  = (QW+5)'(quot * sens_reg) > (QW+5)'(aged_reg);
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (state_reg == ST_FINISH && out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.beat_found     = beat_reg;
                    m_data_next.line_thickness = thick_reg;
                    m_data_next.quiet_start    = quiet_reg;
                    if (beat_reg) begin
                        prev_next = elapsed_reg;
                        base_next = slot_reg;
                        fsb_next  = '0;
                    end else begin
                        fsb_next  = elapsed_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        aged_reg    <= aged_next;
        dev_reg     <= dev_next;
        elapsed_reg <= elapsed_next;
        slot_reg    <= slot_next;
        clear_reg   <= clear_next;
        cand_reg    <= cand_next;
        thick_reg   <= thick_next;
        quiet_reg   <= quiet_next;
        j_reg       <= j_next;
        m_reg       <= m_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        sens_reg    <= sens_next;
        m_data_reg  <= m_data_next;
        vq_reg      <= valid_reg[j_reg];
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sens_cfg_reg  <= 4'd4;
            thick_cfg_reg <= 1'b1;
            smoothed_reg  <= '0;
            fsb_reg       <= '0;
            prev_reg      <= '0;
            base_reg      <= '0;
            was_quiet_reg <= 1'b0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
            beat_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sens_cfg_reg  <= sens_cfg_next;
            thick_cfg_reg <= thick_cfg_next;
            smoothed_reg  <= smoothed_next;
            fsb_reg       <= fsb_next;
            prev_reg      <= prev_next;
            base_reg      <= base_next;
            was_quiet_reg <= was_quiet_next;
            valid_reg     <= valid_next;
            m_valid_reg   <= m_valid_next;
            beat_reg      <= beat_next;
        end
    end

    abd_ram #(
        .WIDTH (DEV_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_WRITE),
        .wr_addr (slot_reg),
        .wr_data (dev_reg),
        .rd_en   (state_reg == ST_SUM_ADDR),
        .rd_addr (j_reg),
        .rd_data (rd_data)
    );

    abd_div #(
        .WIDTH   (QW),
        .DIVISOR (HISTORY_DEPTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg[QW-1:0]),
        .done     (div_done),
        .quotient (quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("sequencer state not one-hot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fsb_reg <= CntW'(HISTORY_DEPTH))
        else $error("beat period count beyond ring depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg < IdxW'(HISTORY_DEPTH) || HISTORY_DEPTH == (1 << IdxW))
        else $error("ring base out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_WRITE)
        else $error("accepted transfer did not start the ring write");
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// audio beat detector testbench
// drives loudness frames under random idling, predicts each result from a
// behavioural model of the detector and compares every result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import abd_pkg::*;

    localparam int DEPTH     = 200;
    localparam int MAX_CYCLE = 2000000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    abd_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    abd_out_t m_data;
    logic     cfg_wr_en = 1'b0;
    logic     cfg_index = 1'b0;
    logic [3:0] cfg_wdata = '0;

    audio_beat_detector_core #(.HISTORY_DEPTH(DEPTH)) DUT (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // predictor state
    logic [3:0]        sens_reg;
    logic              thick_mode;
    logic [LOUD_W-1:0] smooth;
    int unsigned       since_beat, prev_period, ring_base;
    int                dev_ring [DEPTH];
    logic              was_quiet;

    abd_out_t    expected_results [$];
    int          errors = 0;
    int unsigned cycle_count = 0;
    int          send_idle = 0, recv_stall = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic abd_out_t predict_frame(input abd_in_t f);
        abd_out_t    r;
        longint      total, sens, lim;
        int unsigned aged, elapsed, slot, n, j, diff;
        longint unsigned t;
        aged = ((longint'(smooth) * 7 + f.frame_loudness) >> 3) & 32'hFFFFF;
        smooth = aged;
        elapsed = since_beat + 1;
        r = '0;
        if (aged < 2000 || elapsed > DEPTH) begin
            elapsed = 0;
            foreach (dev_ring[i]) dev_ring[i] = 0;
        end
        slot = (ring_base + elapsed) % DEPTH;
        dev_ring[slot] = int'(f.frame_loudness) - int'(aged);
        if (elapsed > 15 && aged > 2000 &&
            longint'(f.frame_loudness) * 4 > longint'(aged) * 5) begin
            total = 0;
            n = DEPTH / elapsed;
            j = slot;
            while (n > 1) begin
                total += dev_ring[j % DEPTH];
                j = (j + DEPTH - elapsed) % DEPTH;
                n--;
            end
            total = total * longint'(elapsed) / DEPTH;
            diff = elapsed > prev_period ? elapsed - prev_period : prev_period - elapsed;
            sens = sens_reg;
            if (diff / 2 < 3) sens += 3 - diff / 2;
            lim = aged;
            if (total * sens > lim) begin
                prev_period = elapsed;
                ring_base = (ring_base + elapsed) % DEPTH;
                elapsed = 0;
                r.beat_found = 1'b1;
            end
        end
        since_beat = elapsed;
        if (aged < 1500) r.line_thickness = 2'd0;
        else if (!thick_mode) r.line_thickness = 2'd1;
        else begin
            t = longint'(f.frame_loudness) * 2 / aged;
            r.line_thickness = t > 3 ? 2'd3 : 2'(t);
        end
        if (f.force_quiet || aged < (was_quiet ? 1500 : 500)) begin
            r.quiet_start = !was_quiet;
            was_quiet = 1'b1;
        end else begin
            was_quiet = 1'b0;
        end
        return r;
    endfunction

    // one frame transfer; valid stays up into the next frame unless the sender idles
    task automatic send_frame(input logic [LOUD_W-1:0] loud, input logic fq);
        abd_in_t f;
        f.frame_loudness = loud;
        f.force_quiet = fq;
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_frame(f));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [3:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SENSITIVITY) sens_reg = val;
        else thick_mode = val[0];
        @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected transfer", 1, 0);
            end else begin
                abd_out_t e;
                e = expected_results.pop_front();
                if (m_data.beat_found !== e.beat_found)
                    report("beat_found", int'(m_data.beat_found), int'(e.beat_found));
                if (m_data.line_thickness !== e.line_thickness)
                    report("line_thickness", int'(m_data.line_thickness),
                           int'(e.line_thickness));
                if (m_data.quiet_start !== e.quiet_start)
                    report("quiet_start", int'(m_data.quiet_start), int'(e.quiet_start));
            end
        end
        m_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
        if (cycle_count > MAX_CYCLE) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_frame(20'd0, 1'b0);
        send_frame(20'hFFFFF, 1'b0);
        send_frame(20'hFFFFF, 1'b1);
        send_frame(20'd0, 1'b1);
        repeat (20) send_frame(20'd3000, 1'b0);
        send_frame(20'd0, 1'b0);
    endtask

    // rhythmic loud pulses over a steady floor, so candidates and beats occur
    task automatic rhythm_burst(input int frames, input int period);
        int unsigned floor_lvl, peak;
        floor_lvl = $urandom_range(9000, 2500);
        peak = floor_lvl * $urandom_range(6, 2);
        for (int i = 0; i < frames; i++) begin
            if ($urandom_range(99) < 4)
                send_frame(20'($urandom), 1'($urandom_range(1)));
            else if (i % period == 0)
                send_frame(20'(peak > 20'hFFFFF ? 20'hFFFFF : peak), 1'b0);
            else
                send_frame(20'(floor_lvl + $urandom_range(400)), $urandom_range(99) < 2);
        end
    endtask

    task automatic test_random(input int frames);
        int done;
        done = 0;
        while (done < frames) begin
            if ($urandom_range(9) == 0) begin
                // quiet tail for the hysteresis
                repeat (10) send_frame(20'($urandom_range(1800)), 1'b0);
                done += 10;
            end else begin
                rhythm_burst(40, $urandom_range(40, 16));
                done += 40;
            end
        end
    endtask

    initial begin
        sens_reg = 4'd4;
        thick_mode = 1'b1;
        smooth = '0;
        since_beat = 0;
        prev_period = 0;
        ring_base = 0;
        foreach (dev_ring[i]) dev_ring[i] = 0;
        was_quiet = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        write_reg(CFG_THICK_MODE, 4'd0);
        test_random(120);
        write_reg(CFG_THICK_MODE, 4'd1);
        write_reg(CFG_SENSITIVITY, 4'd15);
        send_idle = 59;
        test_random(280);
        drain();
        write_reg(CFG_SENSITIVITY, 4'd0);
        send_idle = 0;
        recv_stall = 59;
        test_random(280);
        write_reg(CFG_SENSITIVITY, 4'd7);
        send_idle = 38;
        recv_stall = 38;
        test_random(280);
        send_idle = 0;
        recv_stall = 0;
        test_random(280);
        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
